>>> rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Block geometry, padding constants, initial hash values and the control
// bundle that the sequencer hands to the schedule line and the round unit.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned BlockBytes  = 64;
  localparam int unsigned LenPos      = 56;
  localparam int unsigned Rounds      = 80;
  localparam int unsigned DigestWords = 5;
  localparam int unsigned LineBits    = BlockBytes * 8;

  localparam logic [7:0] PadMark = 8'h80;

  // Element 0 is the most significant digest word.
  localparam logic [DigestWords-1:0][31:0] ChainInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Round groups of twenty rounds each.
  typedef enum logic [1:0] {
    STG_CHOOSE,
    STG_PARITY_LO,
    STG_MAJORITY,
    STG_PARITY_HI
  } stage_e;

  typedef struct packed {
    logic       push;       // shift one byte into the block line
    logic [7:0] push_byte;
    logic       load;       // copy chaining words into the working words
    logic       round;      // run one compression round
    logic       mix;        // round 16 or later: schedule word from the window
    stage_e     stage;
    logic       add;        // fold working words into chaining words
    logic       init;       // restore the initial hash values
  } ctrl_t;

endpackage

>>> rtl/sha1md_sched.sv
// ----------------------------------------------------------------------------
// SHA-1 block line and word schedule
// A 16-word shift line that collects message bytes big-endian and, during
// compression, rolls forward one schedule word per round.
// ----------------------------------------------------------------------------
module sha1md_sched import sha1md_pkg::*; (
  input  logic        clk_i,
  input  ctrl_t       ctrl_i,
  output logic [31:0] sched_o
);

  logic [LineBits-1:0] line_q;
  logic [31:0]         w0, w2, w8, w13, mixed;

  // The oldest word sits at the top of the line.
  assign w0  = line_q[LineBits-1      -: 32];
  assign w2  = line_q[LineBits-1-64   -: 32];
  assign w8  = line_q[LineBits-1-256  -: 32];
  assign w13 = line_q[LineBits-1-416  -: 32];

  assign mixed   = w13 ^ w8 ^ w2 ^ w0;
  assign sched_o = ctrl_i.mix ? {mixed[30:0], mixed[31]} : w0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      line_q <= {line_q[LineBits-9:0], ctrl_i.push_byte};
    end else if (ctrl_i.round) begin
      line_q <= {line_q[LineBits-33:0], sched_o};
    end
  end

endmodule

>>> rtl/sha1md_round.sv
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Five working words and one shared round adder that is stepped eighty times
// per block, plus the five chaining words that collect each block's result.
// ----------------------------------------------------------------------------
module sha1md_round import sha1md_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ctrl_t                           ctrl_i,
  input  logic [31:0]                     sched_i,
  output logic [DigestWords-1:0][31:0]    chain_o
);

  localparam logic [31:0] KChoose   = 32'h5A827999;
  localparam logic [31:0] KParityLo = 32'h6ED9EBA1;
  localparam logic [31:0] KMajority = 32'h8F1BBCDC;
  localparam logic [31:0] KParityHi = 32'hCA62C1D6;

  logic [DigestWords-1:0][31:0] chain_q;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] fn, kc, nxt;

  always_comb begin
    case (ctrl_i.stage)
      STG_CHOOSE: begin
        fn = (b_q & c_q) | (~b_q & d_q);
        kc = KChoose;
      end
      STG_PARITY_LO: begin
        fn = b_q ^ c_q ^ d_q;
        kc = KParityLo;
      end
      STG_MAJORITY: begin
        fn = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
        kc = KMajority;
      end
      default: begin
        fn = b_q ^ c_q ^ d_q;
        kc = KParityHi;
      end
    endcase
  end

  assign nxt = {a_q[26:0], a_q[31:27]} + fn + e_q + kc + sched_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (ctrl_i.round) begin
      a_q <= nxt;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= ChainInit;
    end else if (ctrl_i.init) begin
      chain_q <= ChainInit;
    end else if (ctrl_i.add) begin
      chain_q[0] <= chain_q[0] + a_q;
      chain_q[1] <= chain_q[1] + b_q;
      chain_q[2] <= chain_q[2] + c_q;
      chain_q[3] <= chain_q[3] + d_q;
      chain_q[4] <= chain_q[4] + e_q;
    end
  end

  assign chain_o = chain_q;

endmodule

>>> rtl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Streaming hasher: message bytes in, five digest words out per message.
// ----------------------------------------------------------------------------
// A word carries at most one message byte and may close the message. A word
// with a byte pushes that byte into the block line; a byte that completes a 64-byte
// block is followed by 80 rounds through the shared round adder and one
// chaining add. Closing a message feeds the padding byte, the zero bytes and
// the eight length bytes through the same byte path at one per cycle while no
// compression runs, runs one or two compressions and then presents the five
// digest words. in_stall_o is high while a block, the padding or the digest
// output is being worked on; the last digest word may still wait in the
// output register while the next message starts.
module sha1_message_digest import sha1md_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_ZERO,
    S_LEN,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_e;

  state_e      state_q, state_d, ret_q, ret_d;
  logic [5:0]  fill_q, fill_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  oidx_q, oidx_d;
  logic [63:0] total_q, total_d, len_q, len_d;
  logic        out_valid_q, out_valid_d, last_q, last_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  index_q, index_d;
  ctrl_t       ctrl;
  logic [31:0] sched;
  logic [DigestWords-1:0][31:0] chain;
  state_e      after_push;

  sha1md_sched u_sched (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .sched_o (sched)
  );

  sha1md_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .sched_i (sched),
    .chain_o (chain)
  );

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fill_d      = fill_q;
    rnd_d       = rnd_q;
    oidx_d      = oidx_q;
    total_d     = total_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && out_stall_i;
    word_d      = word_q;
    index_d     = index_q;
    last_d      = last_q;
    after_push  = S_IDLE;

    ctrl           = '0;
    ctrl.mix       = rnd_q >= 7'd16;
    if (rnd_q < 7'd20) begin
      ctrl.stage = STG_CHOOSE;
    end else if (rnd_q < 7'd40) begin
      ctrl.stage = STG_PARITY_LO;
    end else if (rnd_q < 7'd60) begin
      ctrl.stage = STG_MAJORITY;
    end else begin
      ctrl.stage = STG_PARITY_HI;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (has_byte_i) begin
            ctrl.push      = 1'b1;
            ctrl.push_byte = data_byte_i;
            total_d        = total_q + 64'd1;
          end
          if (end_of_message_i) begin
            len_d   = {total_d[60:0], 3'b000};
            state_d = S_MARK;
          end
          after_push = end_of_message_i ? S_MARK : S_IDLE;
        end
      end
      S_MARK: begin
        ctrl.push      = 1'b1;
        ctrl.push_byte = PadMark;
        state_d        = S_ZERO;
        after_push     = S_ZERO;
      end
      S_ZERO: begin
        if (fill_q == 6'(LenPos)) begin
          state_d = S_LEN;
        end else begin
          ctrl.push      = 1'b1;
          ctrl.push_byte = 8'h00;
          after_push     = S_ZERO;
        end
      end
      S_LEN: begin
        ctrl.push      = 1'b1;
        ctrl.push_byte = len_q[63:56];
        len_d          = {len_q[55:0], 8'h00};
        after_push     = S_OUT;
      end
      S_ROUND: begin
        ctrl.round = 1'b1;
        rnd_d      = rnd_q + 7'd1;
        if (rnd_q == 7'(Rounds - 1)) begin
          rnd_d   = '0;
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        ctrl.add = 1'b1;
        state_d  = ret_q;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          word_d      = chain[oidx_q];
          index_d     = oidx_q;
          last_d      = oidx_q == 3'(DigestWords - 1);
          oidx_d      = oidx_q + 3'd1;
          if (oidx_q == 3'(DigestWords - 1)) begin
            // The last word is captured on the same edge that restores the
            // initial hash values.
            ctrl.init = 1'b1;
            total_d   = '0;
            oidx_d    = '0;
            state_d   = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A byte that fills the block starts a compression and remembers where
    // to continue once the chaining add is done.
    if (ctrl.push) begin
      fill_d = fill_q + 6'd1;
      if (fill_q == 6'(BlockBytes - 1)) begin
        ctrl.load = 1'b1;
        ret_d     = after_push;
        state_d   = S_ROUND;
      end
    end
  end

  assign in_stall_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      fill_q      <= '0;
      rnd_q       <= '0;
      oidx_q      <= '0;
      total_q     <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      word_q      <= '0;
      index_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fill_q      <= fill_d;
      rnd_q       <= rnd_d;
      oidx_q      <= oidx_d;
      total_q     <= total_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      word_q      <= word_d;
      index_q     <= index_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = word_q;
  assign word_index_o  = index_q;
  assign last_word_o   = last_q;

  a_len_after_zeros : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LEN |-> fill_q >= 6'(LenPos))
    else $error("length bytes started before the zero padding reached its slot");

  a_round_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROUND |-> rnd_q < 7'(Rounds))
    else $error("round counter ran past the last round");

  a_out_block_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> fill_q == '0)
    else $error("digest output with a partly filled block");

  a_last_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_word_o |-> word_index_o == 3'(DigestWords - 1))
    else $error("last digest word flagged at the wrong index");

  a_add_after_rounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADD |-> $past(state_q) == S_ROUND)
    else $error("chaining add without a finished round pass");

endmodule

>>> verif/sha1md_digest_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches both word channels of the hasher, recomputes the digest of every
// message from the accepted input words and compares each digest word, in
// order, against what the hasher delivers.
// ----------------------------------------------------------------------------
module sha1md_digest_check import sha1md_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic [31:0]  chain [DigestWords];
  logic [7:0]   blk [BlockBytes];
  int unsigned  fill;
  logic [63:0]  total;
  digest_item_t digest_q [$];

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // One 80-round compression of the block store into the chaining words.
  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, s, t;
    stage_e      grp;
    for (int r = 0; r < 16; r++) begin
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < Rounds; r++) begin
      if (r < 16) begin
        s = w[r];
      end else begin
        s = rol(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
        w[r%16] = s;
      end
      grp = stage_e'(r / 20);
      case (grp)
        STG_CHOOSE: begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end
        STG_PARITY_LO: begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end
        STG_MAJORITY: begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end
        default: begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
      endcase
      t = rol(a, 5) + f + e + k + s;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void sha1_restart();
    for (int i = 0; i < DigestWords; i++) begin
      chain[i] = ChainInit[i];
    end
    fill  = 0;
    total = '0;
  endfunction

  // Takes one accepted input word; on a close it queues the five digest words.
  function automatic void sha1_absorb(input logic [7:0] b, input logic hb, input logic eom);
    logic [63:0]  bits;
    digest_item_t item;
    if (hb) begin
      blk[fill] = b;
      fill++;
      total++;
      if (fill == BlockBytes) begin
        sha1_compress();
        fill = 0;
      end
    end
    if (!eom) return;
    bits = total << 3;
    blk[fill] = PadMark;
    fill++;
    // No room left for the length: pad out this block and use a second one.
    if (fill > LenPos) begin
      while (fill < BlockBytes) begin
        blk[fill] = 8'h00;
        fill++;
      end
      sha1_compress();
      fill = 0;
    end
    while (fill < LenPos) begin
      blk[fill] = 8'h00;
      fill++;
    end
    for (int i = 0; i < 8; i++) begin
      blk[LenPos + i] = bits[63 - 8*i -: 8];
    end
    sha1_compress();
    for (int i = 0; i < DigestWords; i++) begin
      item.word  = chain[i];
      item.index = 3'(i);
      item.last  = (i == DigestWords - 1);
      digest_q.push_back(item);
    end
    sha1_restart();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digest_item_t want;
    if (!rst_ni) begin
      sha1_restart();
      digest_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        sha1_absorb(data_byte_i, has_byte_i, end_of_message_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("unexpected digest word: %08h idx %0d last %0b",
                     digest_word_i, word_index_i, last_word_i);
          end
        end else begin
          want = digest_q.pop_front();
          if (digest_word_i !== want.word || word_index_i !== want.index ||
              last_word_i !== want.last) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("digest word mismatch: expected %08h idx %0d last %0b,",
                       want.word, want.index, want.last,
                       " got %08h idx %0d last %0b",
                       digest_word_i, word_index_i, last_word_i);
            end
          end
        end
      end
      pending_o = digest_q.size();
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Feeds the hasher directed and random messages, including lengths around
// the padding boundaries, with random gaps on both sides and one long output
// hold-off, while the digest checker recomputes and compares every word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned ItemTarget  = 380;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned CycleLimit  = 600000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  bit          steady;
  bit          hold_request;

  sha1_message_digest u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .has_byte_i       (has_byte),
    .end_of_message_i (end_of_message),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .digest_word_o    (digest_word),
    .word_index_o     (word_index),
    .last_word_o      (last_word)
  );

  sha1md_digest_check u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .has_byte_i       (has_byte),
    .end_of_message_i (end_of_message),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .digest_word_i    (digest_word),
    .word_index_i     (word_index),
    .last_word_i      (last_word),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Outside steady phases, each cycle before the word is offered is idle with a chance of 19 in 100.
  task automatic send_word(input logic [7:0] b, input logic hb, input logic eom);
    while (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    has_byte       <= hb;
    end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int unsigned items;
    int unsigned msg;
    int unsigned len;
    bit          close_on_byte;
    in_valid       = 1'b0;
    data_byte      = 8'h00;
    has_byte       = 1'b0;
    end_of_message = 1'b0;
    steady         = 1'b0;
    hold_request   = 1'b0;
    rst_n          = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty message; the byte lane carries junk that must be ignored.
    send_word(8'hA5, 1'b0, 1'b1);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'h7F, 1'b1, 1'b0);
    send_word(8'hFE, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b0, 1'b1);

    // Random messages, a good share of them at lengths where the padding
    // just fits or spills into a second block.
    items = 0;
    msg   = 0;
    while (items < ItemTarget) begin
      steady = (msg >= 10 && msg < 16);
      if (msg == 4) hold_request = 1'b1;
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(5))
          0: len = 0;
          1: len = 55;
          2: len = 56;
          3: len = 63;
          4: len = 64;
          default: len = 119;
        endcase
      end else begin
        len = $urandom_range(1, 20);
      end
      close_on_byte = (len != 0) && ($urandom_range(1) == 1);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(15) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
        send_word(8'($urandom_range(255)), 1'b1, close_on_byte && (j == len - 1));
        items++;
      end
      if (!close_on_byte) begin
        send_word(8'($urandom_range(255)), 1'b0, 1'b1);
        items++;
      end
      msg++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Output side: random stalls, plus one long hold-off so that the hasher
  // backs up and stalls its input.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall <= !steady && ($urandom_range(99) < 19);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
